>>> sv/dssm_pkg.sv
package dssm_pkg;

    // Event codes carried on the opcode field
    typedef enum logic [2:0] {
        OP_TICK           = 3'd0,
        OP_CHANGE_SESSION = 3'd1,
        OP_CHECK_ACCESS   = 3'd2,
        OP_REQUEST_SEED   = 3'd3,
        OP_SEND_KEY       = 3'd4
    } op_t;

    // Diagnostic sessions; code zero is never used
    typedef enum logic [1:0] {
        SESS_DEFAULT     = 2'd1,
        SESS_EXTENDED    = 2'd2,
        SESS_PROGRAMMING = 2'd3
    } sess_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SESSION_TIMEOUT = 2'd0,
        CFG_SEED_VALUE      = 2'd1,
        CFG_KEY_MASK        = 2'd2
    } cfg_idx_t;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned TIMEOUT_W   = 16;
    localparam int unsigned SEED_W      = 32;
    localparam int unsigned SID_W       = 8;
    localparam int unsigned REQ_W       = 8;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd5000;
    localparam logic [SEED_W-1:0]    SEED_RESET    = 32'hDEADBEEF;
    localparam logic [SEED_W-1:0]    MASK_RESET    = 32'hCAFEBABE;

    localparam int unsigned RULE_COUNT_DEFAULT = 8;
    localparam int unsigned TIMER_BITS_DEFAULT = 16;

    // Access rule: service ID and the sessions that allow it
    typedef struct packed {
        logic [SID_W-1:0] sid;
        logic             in_default;
        logic             in_extended;
        logic             in_programming;
    } rule_t;

    localparam int unsigned RULE_TABLE_SIZE = 8;

    localparam rule_t RULE_TABLE [RULE_TABLE_SIZE] = '{
        '{sid: 8'h10, in_default: 1'b1, in_extended: 1'b1, in_programming: 1'b1},
        '{sid: 8'h11, in_default: 1'b0, in_extended: 1'b1, in_programming: 1'b1},
        '{sid: 8'h14, in_default: 1'b0, in_extended: 1'b1, in_programming: 1'b0},
        '{sid: 8'h19, in_default: 1'b1, in_extended: 1'b1, in_programming: 1'b0},
        '{sid: 8'h22, in_default: 1'b1, in_extended: 1'b1, in_programming: 1'b0},
        '{sid: 8'h27, in_default: 1'b0, in_extended: 1'b1, in_programming: 1'b1},
        '{sid: 8'h2E, in_default: 1'b0, in_extended: 1'b0, in_programming: 1'b1},
        '{sid: 8'h31, in_default: 1'b0, in_extended: 1'b1, in_programming: 1'b1}
    };

endpackage

>>> sv/diag_session_security_manager.sv
// Diagnostic session and security-access manager.
// Input channel (s_valid/s_ready): one event word per handshake, chosen by
// s_opcode: tick, change session, check access, request seed, send key.
// Result channel (m_valid/m_ready): exactly one result word per event,
// giving refusal, issued seed, the session and lock state after the event.
// Configuration: cfg_wr_en with cfg_index and cfg_data writes session
// timeout (0), seed value (1) or key mask (2); write only
// while no event is in flight.
// Latency: an accepted event is resolved in the accept cycle and its
// result word is valid on the next cycle. Throughput: one event per cycle
// while results are taken; the state update and rule lookup are one level
// of logic ahead of the result register.
// Stall: while a result waits and m_ready is low, s_ready is low; when the
// result is taken, a new event is accepted in that same cycle.
// Reset (aresetn low, synchronous): default session, locked, timer and
// pending seed cleared, configuration back to its defaults, no result.
module diag_session_security_manager
    import dssm_pkg::*;
#(
    parameter int unsigned RULE_COUNT = RULE_COUNT_DEFAULT,
    parameter int unsigned TIMER_BITS = TIMER_BITS_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // event input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_opcode,
    input  logic [REQ_W-1:0]       s_session_request,
    input  logic [SID_W-1:0]       s_service_id,
    input  logic [SEED_W-1:0]      s_key_value,
    // result output
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_not_ok,
    output logic [SEED_W-1:0]      m_seed_out,
    output logic [1:0]             m_current_session,
    output logic                   m_unlocked
);

    localparam int unsigned CMP_W = (TIMER_BITS > TIMEOUT_W) ? TIMER_BITS : TIMEOUT_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // configuration registers
    logic [TIMEOUT_W-1:0]  timeout_reg;
    logic [SEED_W-1:0]     seed_value_reg;
    logic [SEED_W-1:0]     key_mask_reg;

    // session state
    sess_t                 session_reg,   session_next;
    logic                  unlocked_reg,  unlocked_next;
    logic [TIMER_BITS-1:0] timer_reg,     timer_next;
    logic                  pending_reg,   pending_next;
    logic [SEED_W-1:0]     last_seed_reg, last_seed_next;

    // result register
    logic                  m_valid_reg;
    logic                  not_ok_reg,    not_ok_next;
    logic [SEED_W-1:0]     seed_out_reg,  seed_out_next;

    logic                  accept;
    logic                  rule_hit;
    logic                  rule_allow;
    logic [TIMER_BITS-1:0] timer_inc;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Look up the service ID for the current session
    always_comb begin
        rule_hit   = 1'b0;
        rule_allow = 1'b0;
        for (int i = 0; i < RULE_TABLE_SIZE; i++) begin
            if (i < RULE_COUNT && !rule_hit && RULE_TABLE[i].sid == s_service_id) begin
                rule_hit = 1'b1;
                case (session_reg)
                    SESS_DEFAULT:     rule_allow = RULE_TABLE[i].in_default;
                    SESS_EXTENDED:    rule_allow = RULE_TABLE[i].in_extended;
                    SESS_PROGRAMMING: rule_allow = RULE_TABLE[i].in_programming;
                    default:          rule_allow = 1'b0;
                endcase
            end
        end
    end

    // Saturating timer increment
    assign timer_inc = (timer_reg < TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;

    // Resolve one event against the current state
    always_comb begin
        session_next   = session_reg;
        unlocked_next  = unlocked_reg;
        timer_next     = timer_reg;
        pending_next   = pending_reg;
        last_seed_next = last_seed_reg;
        not_ok_next    = 1'b1;
        seed_out_next  = '0;
        case (op_t'(s_opcode))
            OP_TICK: begin
                not_ok_next = 1'b0;
                if (session_reg != SESS_DEFAULT) begin
                    timer_next = timer_inc;
                    if (CMP_W'(timer_inc) >= CMP_W'(timeout_reg)) begin
                        session_next  = SESS_DEFAULT;
                        timer_next    = '0;
                        unlocked_next = 1'b0;
                    end
                end
            end
            OP_CHANGE_SESSION: begin
                if (s_session_request == REQ_W'(SESS_DEFAULT) ||
                    s_session_request == REQ_W'(SESS_EXTENDED) ||
                    s_session_request == REQ_W'(SESS_PROGRAMMING)) begin
                    session_next = sess_t'(s_session_request[1:0]);
                    timer_next   = '0;
                    not_ok_next  = 1'b0;
                    if (s_session_request == REQ_W'(SESS_DEFAULT)) begin
                        unlocked_next = 1'b0;
                    end
                end
            end
            OP_CHECK_ACCESS: begin
                not_ok_next = !rule_allow;
            end
            OP_REQUEST_SEED: begin
                if (session_reg != SESS_DEFAULT) begin
                    last_seed_next = seed_value_reg;
                    pending_next   = 1'b1;
                    seed_out_next  = seed_value_reg;
                    not_ok_next    = 1'b0;
                end
            end
            OP_SEND_KEY: begin
                if (pending_reg) begin
                    pending_next = 1'b0;
                    if (s_key_value == (last_seed_reg ^ key_mask_reg)) begin
                        unlocked_next = 1'b1;
                        not_ok_next   = 1'b0;
                    end
                end
            end
            default: begin
                not_ok_next = 1'b1;
            end
        endcase
    end

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= TIMEOUT_RESET;
            seed_value_reg <= SEED_RESET;
            key_mask_reg   <= MASK_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_SESSION_TIMEOUT: timeout_reg    <= cfg_data[TIMEOUT_W-1:0];
                CFG_SEED_VALUE:      seed_value_reg <= cfg_data[SEED_W-1:0];
                CFG_KEY_MASK:        key_mask_reg   <= cfg_data[SEED_W-1:0];
                default:             ;
            endcase
        end
    end

    // Advance session state on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg <= SESS_DEFAULT;
            unlocked_reg <= 1'b0;
            timer_reg   <= '0;
            pending_reg <= 1'b0;
        end else if (accept) begin
            session_reg  <= session_next;
            unlocked_reg <= unlocked_next;
            timer_reg    <= timer_next;
            pending_reg  <= pending_next;
        end
    end

    // Hold the seed only when one is issued
    always_ff @(posedge aclk) begin
        if (accept) begin
            last_seed_reg <= last_seed_next;
        end
    end

    // Result word valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            not_ok_reg   <= not_ok_next;
            seed_out_reg <= seed_out_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_not_ok          = not_ok_reg;
    assign m_seed_out        = seed_out_reg;
    assign m_current_session = session_reg;
    assign m_unlocked        = unlocked_reg;

    // Hold a waiting result word until it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready
        |=> m_valid && $stable(m_not_ok) && $stable(m_seed_out) &&
            $stable(m_current_session) && $stable(m_unlocked))
        else $error("result word changed while stalled");

    // A granted seed request leaves a seed pending with that seed
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_opcode == OP_REQUEST_SEED && session_reg != SESS_DEFAULT
        |=> pending_reg && m_seed_out == last_seed_reg && !m_not_ok)
        else $error("seed request did not leave a pending seed");

    // A key word always consumes any pending seed
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_opcode == OP_SEND_KEY |=> !pending_reg)
        else $error("pending seed survived a key word");

    // State moves only with an accepted word
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(session_reg) && $stable(unlocked_reg))
        else $error("session state changed without an event");

endmodule

>>> sim/diag_session_security_manager_tb.sv
`timescale 1ns / 100ps

module diag_session_security_manager_tb;
    import dssm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 210;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam logic [2:0] OP_UNUSED_FIRST = 3'(OP_SEND_KEY) + 3'd1;
    localparam logic [2:0] OP_UNUSED_LAST = '1;

    // One result word as the block reports it
    typedef struct packed {
        logic              not_ok;
        logic [SEED_W-1:0] seed;
        logic [1:0]        session;
        logic              unlocked;
    } verdict_t;

    // Tracks session, lock, timer and seed state; queues one verdict per event
    class session_scoreboard;
        logic [TIMEOUT_W-1:0] timeout;
        logic [SEED_W-1:0] seed_cfg;
        logic [SEED_W-1:0] mask;
        sess_t sess;
        logic unlocked;
        logic seed_pending;
        logic [TIMER_BITS_DEFAULT-1:0] timer;
        logic [SEED_W-1:0] last_seed;
        verdict_t awaited[$];
        int errors;
        int events;
        int checked;
        int unlocks;
        int fallbacks;
        int odd_ops;

        function new();
            timeout = TIMEOUT_RESET;
            seed_cfg = SEED_RESET;
            mask = MASK_RESET;
            sess = SESS_DEFAULT;
            unlocked = 1'b0;
            seed_pending = 1'b0;
            timer = '0;
            last_seed = '0;
            errors = 0;
            events = 0;
            checked = 0;
            unlocks = 0;
            fallbacks = 0;
            odd_ops = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SESSION_TIMEOUT: timeout = data[TIMEOUT_W-1:0];
                CFG_SEED_VALUE:      seed_cfg = data[SEED_W-1:0];
                CFG_KEY_MASK:        mask = data[SEED_W-1:0];
                default: ;
            endcase
        endfunction

        function void enter(sess_t s);
            sess = s;
            timer = '0;
            if (s == SESS_DEFAULT) unlocked = 1'b0;
        endfunction

        function void note_event(logic [2:0] op, logic [REQ_W-1:0] req,
                                 logic [SID_W-1:0] sid, logic [SEED_W-1:0] key);
            verdict_t v;
            logic hit;
            logic allowed;
            v = '0;
            v.not_ok = 1'b1;
            hit = 1'b0;
            allowed = 1'b0;
            events++;
            case (op)
                OP_TICK: begin
                    v.not_ok = 1'b0;
                    // count only outside default; saturate, then fall back on expiry
                    if (sess != SESS_DEFAULT) begin
                        if (timer != '1) timer = timer + 1'b1;
                        if (timer >= timeout) begin
                            enter(SESS_DEFAULT);
                            fallbacks++;
                        end
                    end
                end
                OP_CHANGE_SESSION: begin
                    if (req == REQ_W'(SESS_DEFAULT) || req == REQ_W'(SESS_EXTENDED) ||
                        req == REQ_W'(SESS_PROGRAMMING)) begin
                        enter(sess_t'(req[1:0]));
                        v.not_ok = 1'b0;
                    end
                end
                OP_CHECK_ACCESS: begin
                    // first matching rule decides for the current session
                    for (int i = 0; i < RULE_TABLE_SIZE; i++) begin
                        if (!hit && RULE_TABLE[i].sid == sid) begin
                            hit = 1'b1;
                            case (sess)
                                SESS_DEFAULT:     allowed = RULE_TABLE[i].in_default;
                                SESS_EXTENDED:    allowed = RULE_TABLE[i].in_extended;
                                SESS_PROGRAMMING: allowed = RULE_TABLE[i].in_programming;
                                default:          allowed = 1'b0;
                            endcase
                        end
                    end
                    v.not_ok = !allowed;
                end
                OP_REQUEST_SEED: begin
                    if (sess != SESS_DEFAULT) begin
                        last_seed = seed_cfg;
                        seed_pending = 1'b1;
                        v.seed = last_seed;
                        v.not_ok = 1'b0;
                    end
                end
                OP_SEND_KEY: begin
                    // any key consumes the pending seed
                    if (seed_pending) begin
                        seed_pending = 1'b0;
                        if (key == (last_seed ^ mask)) begin
                            unlocked = 1'b1;
                            v.not_ok = 1'b0;
                            unlocks++;
                        end
                    end
                end
                default: odd_ops++;
            endcase
            v.session = sess;
            v.unlocked = unlocked;
            awaited.push_back(v);
        endfunction

        function void check_result(logic not_ok, logic [SEED_W-1:0] seed,
                                   logic [1:0] session, logic unl);
            verdict_t v;
            if (awaited.size() == 0) begin
                $error("result word with no event outstanding");
                errors++;
                return;
            end
            v = awaited.pop_front();
            checked++;
            if (not_ok !== v.not_ok) begin
                $error("not_ok: expected %0d, got %0d", v.not_ok, not_ok);
                errors++;
            end
            if (seed !== v.seed) begin
                $error("seed_out: expected %08h, got %08h", v.seed, seed);
                errors++;
            end
            if (session !== v.session) begin
                $error("current_session: expected %0d, got %0d", v.session, session);
                errors++;
            end
            if (unl !== v.unlocked) begin
                $error("unlocked: expected %0d, got %0d", v.unlocked, unl);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic s_valid;
    logic s_ready;
    logic [2:0] s_opcode;
    logic [REQ_W-1:0] s_session_request;
    logic [SID_W-1:0] s_service_id;
    logic [SEED_W-1:0] s_key_value;
    logic m_valid;
    logic m_ready;
    logic m_not_ok;
    logic [SEED_W-1:0] m_seed_out;
    logic [1:0] m_current_session;
    logic m_unlocked;

    session_scoreboard board;
    bit src_idle = 1'b1;
    bit sink_idle = 1'b1;
    int sink_hold = 0;
    int cycle_count = 0;
    int settings = 0;
    logic [SEED_W-1:0] seed_now = SEED_RESET;
    logic [SEED_W-1:0] mask_now = MASK_RESET;

    diag_session_security_manager uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_session_request (s_session_request),
        .s_service_id      (s_service_id),
        .s_key_value       (s_key_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_not_ok          (m_not_ok),
        .m_seed_out        (m_seed_out),
        .m_current_session (m_current_session),
        .m_unlocked        (m_unlocked)
    );

    always #5 aclk = ~aclk;

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("diag_session_security_manager verification failed");
            $finish;
        end
    end

    // Record accepted event words, then compare accepted result words
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            board.note_event(s_opcode, s_session_request, s_service_id, s_key_value);
        if (aresetn && m_valid && m_ready)
            board.check_result(m_not_ok, m_seed_out, m_current_session, m_unlocked);
    end

    // Result side: random stall per word while sink_idle is set, plus a long hold-off on request
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            stall = sink_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Offer one event word and hold it until accepted
    task automatic send_event(input logic [2:0] op, input logic [REQ_W-1:0] req,
                              input logic [SID_W-1:0] sid, input logic [SEED_W-1:0] key);
        int gap;
        gap = src_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_session_request <= req;
        s_service_id <= sid;
        s_key_value <= key;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (board.awaited.size() != 0) @(posedge aclk);
    endtask

    // Write all three registers while the block is idle
    task automatic program_regs(input logic [TIMEOUT_W-1:0] tmo,
                                input logic [SEED_W-1:0] seed,
                                input logic [SEED_W-1:0] mask);
        logic [CFG_DATA_W-1:0] word;
        drain();
        repeat (3) @(posedge aclk);
        // upper bits of the timeout word are junk; only the low field counts
        word = {16'($urandom), tmo};
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SESSION_TIMEOUT;
        cfg_data <= word;
        board.write_reg(CFG_SESSION_TIMEOUT, word);
        @(posedge aclk);
        cfg_index <= CFG_SEED_VALUE;
        cfg_data <= seed;
        board.write_reg(CFG_SEED_VALUE, seed);
        @(posedge aclk);
        cfg_index <= CFG_KEY_MASK;
        cfg_data <= mask;
        board.write_reg(CFG_KEY_MASK, mask);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        seed_now = seed;
        mask_now = mask;
        settings++;
    endtask

    // Mostly plausible tester traffic with random content, some noise
    task automatic random_event();
        int pick;
        logic [2:0] op;
        logic [REQ_W-1:0] req;
        logic [SID_W-1:0] sid;
        logic [SEED_W-1:0] key;
        pick = $urandom_range(0, 99);
        req = $urandom;
        sid = $urandom;
        key = $urandom;
        op = OP_TICK;
        if (pick < 10) begin
            // full unlock attempt: enter a session, get a seed, answer it
            send_event(OP_CHANGE_SESSION,
                       REQ_W'($urandom_range(SESS_EXTENDED, SESS_PROGRAMMING)), sid, key);
            send_event(OP_REQUEST_SEED, req, sid, key);
            op = OP_SEND_KEY;
            key = seed_now ^ mask_now;
            if ($urandom_range(0, 3) == 0) key[$urandom_range(0, SEED_W-1)] ^= 1'b1;
        end else if (pick < 35) begin
            op = OP_TICK;
        end else if (pick < 47) begin
            op = OP_CHANGE_SESSION;
            if ($urandom_range(0, 3) != 0)
                req = REQ_W'($urandom_range(SESS_DEFAULT, SESS_PROGRAMMING));
        end else if (pick < 65) begin
            op = OP_CHECK_ACCESS;
            if ($urandom_range(0, 3) != 0)
                sid = RULE_TABLE[$urandom_range(0, RULE_TABLE_SIZE-1)].sid;
        end else if (pick < 78) begin
            op = OP_REQUEST_SEED;
        end else if (pick < 94) begin
            op = OP_SEND_KEY;
            case ($urandom_range(0, 2))
                0: key = seed_now ^ mask_now;
                1: key = (seed_now ^ mask_now) ^ (32'h1 << $urandom_range(0, SEED_W-1));
                default: ;
            endcase
        end else begin
            op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end
        send_event(op, req, sid, key);
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_SESSION_TIMEOUT;
        cfg_data = '0;
        s_valid = 1'b0;
        s_opcode = OP_TICK;
        s_session_request = '0;
        s_service_id = '0;
        s_key_value = '0;
        m_ready = 1'b0;
        board = new();

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default session: rule lookups, refused seed and key, idle tick
        send_event(OP_CHECK_ACCESS, 8'h00, 8'h10, '0);
        send_event(OP_CHECK_ACCESS, 8'hFF, 8'h11, '1);
        send_event(OP_CHECK_ACCESS, 8'h00, 8'hFF, '0);
        send_event(OP_REQUEST_SEED, 8'h00, 8'h00, '0);
        send_event(OP_SEND_KEY, 8'h00, 8'h00, SEED_RESET ^ MASK_RESET);
        send_event(OP_TICK, 8'hFF, 8'hFF, '1);
        for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
            send_event(3'(op), $urandom, $urandom, $urandom);
        // rejected session values, including two whose low bits look valid
        send_event(OP_CHANGE_SESSION, 8'h00, 8'h00, '0);
        send_event(OP_CHANGE_SESSION, 8'h04, 8'h00, '0);
        send_event(OP_CHANGE_SESSION, 8'h41, 8'h00, '0);
        send_event(OP_CHANGE_SESSION, 8'hFF, 8'h00, '0);
        // wrong key consumes the seed; a second key then finds none pending
        send_event(OP_CHANGE_SESSION, REQ_W'(SESS_EXTENDED), 8'h00, '0);
        send_event(OP_REQUEST_SEED, 8'h00, 8'h00, '0);
        send_event(OP_SEND_KEY, 8'h00, 8'h00, '0);
        send_event(OP_SEND_KEY, 8'h00, 8'h00, SEED_RESET ^ MASK_RESET);
        // repeated seed request replaces the pending one, then unlock
        send_event(OP_REQUEST_SEED, 8'h00, 8'h00, '0);
        send_event(OP_REQUEST_SEED, 8'h00, 8'h00, '0);
        send_event(OP_SEND_KEY, 8'h00, 8'h00, SEED_RESET ^ MASK_RESET);
        // unlock survives a move to programming; default relocks
        send_event(OP_CHANGE_SESSION, REQ_W'(SESS_PROGRAMMING), 8'h00, '0);
        send_event(OP_CHECK_ACCESS, 8'h00, 8'h2E, '0);
        send_event(OP_CHECK_ACCESS, 8'h00, 8'h14, '0);
        send_event(OP_TICK, 8'h00, 8'h00, '0);
        send_event(OP_CHANGE_SESSION, REQ_W'(SESS_DEFAULT), 8'h00, '0);

        // random phases, each under its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: program_regs('0, '0, '0);
                1: program_regs(16'd1, '1, '1);
                2: program_regs('1, $urandom, $urandom);
                5: program_regs(16'($urandom_range(2, 40)), $urandom, '0);
                default: program_regs(16'($urandom_range(2, 40)), $urandom, $urandom);
            endcase
            src_idle = (ph % 3) != 1;
            sink_idle = (ph % 3) != 2;
            // back up the result side while events keep coming
            if (ph == 4) sink_hold = HOLD_OFF_CYCLES;
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                if (ph == 3 && n == WORDS_PER_PHASE / 2) drain();
                random_event();
            end
        end

        drain();
        repeat (5) @(posedge aclk);
        $display("Covered %0d events (%0d unused opcodes) over %0d register settings",
                 board.events, board.odd_ops, settings);
        $display("%0d results compared, %0d unlocks, %0d timeout fallbacks",
                 board.checked, board.unlocks, board.fallbacks);
        if (board.errors == 0 && board.awaited.size() == 0) begin
            $display("diag_session_security_manager verification clean");
        end else begin
            $display("diag_session_security_manager verification failed");
        end
        $finish;
    end

endmodule

>>> diag_session_security_manager.f
sv/dssm_pkg.sv
sv/diag_session_security_manager.sv
sim/diag_session_security_manager_tb.sv
